// ===== hw/rtl/afr_pkg.sv =====
package afr_pkg;

    // cross products run on components brought to 32-bit signed range
    localparam int RED_W   = 32;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic             cap;
        logic [2:0]       xneg;
        logic [2:0][31:0] xmag;
        logic [2:0]       yneg;
        logic [2:0][63:0] ymag;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SQUARE,
        ST_ROOT,
        ST_DIVIDE,
        ST_STORE,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/afr_front.sv =====
module afr_front #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic signed [DATA_WIDTH-1:0] i_nx,
    input  logic signed [DATA_WIDTH-1:0] i_ny,
    input  logic signed [DATA_WIDTH-1:0] i_nz,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output afr_pkg::t_item               o_item,
    output logic [3*DATA_WIDTH-1:0]      o_zrow
);
    import afr_pkg::*;

    localparam logic [63:0] THR = 64'd1 << (FRAC_BITS - 6);

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        logic [63:0] r;
        r = v[63] ? 64'(-v) : 64'(v);
        return r;
    endfunction

    logic signed [RED_W-1:0] w_n [3];
    logic [DATA_WIDTH-1:0]   w_mag_x, w_mag_y;
    logic                    w_cap;

    generate
        if (DATA_WIDTH >= RED_W) begin : g_red
            assign w_n[0] = i_nx[DATA_WIDTH-1 -: RED_W];
            assign w_n[1] = i_ny[DATA_WIDTH-1 -: RED_W];
            assign w_n[2] = i_nz[DATA_WIDTH-1 -: RED_W];
        end else begin : g_ext
            assign w_n[0] = RED_W'(i_nx);
            assign w_n[1] = RED_W'(i_ny);
            assign w_n[2] = RED_W'(i_nz);
        end
    endgenerate

    assign w_mag_x = i_nx[DATA_WIDTH-1] ? DATA_WIDTH'(-i_nx) : DATA_WIDTH'(i_nx);
    assign w_mag_y = i_ny[DATA_WIDTH-1] ? DATA_WIDTH'(-i_ny) : DATA_WIDTH'(i_ny);
    assign w_cap   = (64'(w_mag_x) < THR) && (64'(w_mag_y) < THR);

    // stage A: reduced components and cap test
    logic                    r_a_v;
    logic signed [RED_W-1:0] r_a_n [3];
    logic                    r_a_cap;
    logic [3*DATA_WIDTH-1:0] r_a_z;

    // stage B: products and the X axis direction
    logic                    r_b_v;
    logic                    r_b_cap;
    logic signed [63:0]      r_b_pa, r_b_pb, r_b_sa, r_b_sb;
    logic [2:0]              r_b_xneg;
    logic [2:0][31:0]        r_b_xmag;
    logic [3*DATA_WIDTH-1:0] r_b_z;

    logic w_a_ready, w_b_ready, w_accept, w_b_adv;

    assign w_b_ready = !r_b_v || !i_q_full;
    assign w_a_ready = !r_a_v || w_b_ready;
    assign w_accept  = i_push && w_a_ready;
    assign w_b_adv   = r_a_v && w_b_ready;
    assign o_full    = !w_a_ready;
    assign o_q_push  = r_b_v && !i_q_full;

    logic signed [RED_W-1:0] w_opa, w_ops;
    logic signed [63:0]      w_pa, w_pb, w_sa, w_sb;
    logic [2:0]              w_xneg;
    logic [2:0][31:0]        w_xmag;

    // cap: X = (nz, 0, -nx); otherwise X = (-ny, nx, 0)
    assign w_opa = r_a_cap ? r_a_n[1] : r_a_n[2];
    assign w_ops = r_a_cap ? r_a_n[2] : r_a_n[1];
    assign w_pa  = r_a_n[0] * w_opa;
    assign w_pb  = r_a_n[1] * r_a_n[2];
    assign w_sa  = r_a_n[0] * r_a_n[0];
    assign w_sb  = w_ops * w_ops;

    always_comb begin
        if (r_a_cap) begin
            w_xneg    = {(r_a_n[0] > 0), 1'b0, r_a_n[2][RED_W-1]};
            w_xmag[0] = abs32(r_a_n[2]);
            w_xmag[1] = '0;
            w_xmag[2] = abs32(r_a_n[0]);
        end else begin
            w_xneg    = {1'b0, r_a_n[0][RED_W-1], (r_a_n[1] > 0)};
            w_xmag[0] = abs32(r_a_n[1]);
            w_xmag[1] = abs32(r_a_n[0]);
            w_xmag[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_v <= i_push;
            end
            if (w_b_ready) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_n[0] <= w_n[0];
            r_a_n[1] <= w_n[1];
            r_a_n[2] <= w_n[2];
            r_a_cap  <= w_cap;
            r_a_z    <= {i_nz, i_ny, i_nx};
        end
        if (w_b_adv) begin
            r_b_cap  <= r_a_cap;
            r_b_pa   <= w_pa;
            r_b_pb   <= w_pb;
            r_b_sa   <= w_sa;
            r_b_sb   <= w_sb;
            r_b_xneg <= w_xneg;
            r_b_xmag <= w_xmag;
            r_b_z    <= r_a_z;
        end
    end

    // Y = N x X; components are -pa, -pb and a sum of squares
    logic [63:0] w_sum;
    logic        w_na, w_nb;

    assign w_sum = 64'(r_b_sa) + 64'(r_b_sb);
    assign w_na  = !r_b_pa[63] && (r_b_pa != 0);
    assign w_nb  = !r_b_pb[63] && (r_b_pb != 0);

    always_comb begin
        o_item.cap     = r_b_cap;
        o_item.xneg    = r_b_xneg;
        o_item.xmag    = r_b_xmag;
        o_item.ymag[0] = abs64(r_b_pa);
        if (r_b_cap) begin
            o_item.yneg    = {w_nb, 1'b0, w_na};
            o_item.ymag[1] = w_sum;
            o_item.ymag[2] = abs64(r_b_pb);
        end else begin
            o_item.yneg    = {1'b0, w_nb, w_na};
            o_item.ymag[1] = abs64(r_b_pb);
            o_item.ymag[2] = w_sum;
        end
    end

    assign o_zrow = r_b_z;

endmodule

// ===== hw/rtl/afr_queue.sv =====
module afr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    import afr_pkg::*;

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_AW:0]    r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/afr_back.sv =====
module afr_back #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  afr_pkg::t_item                   i_item,
    input  logic [3*DATA_WIDTH-1:0]          i_zrow,
    output logic                             o_q_pop,
    input  logic                             i_pop,
    output logic                             o_empty,
    output logic [2:0][DATA_WIDTH-1:0]       o_xaxis,
    output logic [2:0][DATA_WIDTH-1:0]       o_yaxis,
    output logic [3*DATA_WIDTH-1:0]          o_zrow,
    output logic                             o_cap,
    output logic                             o_degen
);
    import afr_pkg::*;

    localparam int          CW  = (FRAC_BITS > 31) ? $clog2(FRAC_BITS + 1) : 5;
    localparam logic [63:0] LIM = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;

    function automatic logic [DATA_WIDTH-1:0] enc(input logic neg, input logic [63:0] q);
        logic [63:0] s;
        if (!neg) begin
            s = (q > LIM) ? LIM : q;
        end else begin
            s = (q > LIM + 64'd1) ? LIM + 64'd1 : q;
            s = 64'd0 - s;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    t_state r_state, n_state;
    logic   [CW-1:0] r_cnt;
    logic   r_vsel, r_degen, r_ov;
    logic   [63:0] r_m [3];
    logic   [63:0] r_len2, r_res, r_bit;
    logic   [31:0] r_rem [3];
    logic   [63:0] r_q [3];
    logic   [2:0][DATA_WIDTH-1:0] r_x, r_y;

    // load source: X mags from idle, Y mags after X is stored
    logic        w_src_y;
    logic [63:0] w_ld_m [3];
    logic        w_zero, w_hi, w_lo, w_out_free;

    assign w_src_y = (r_state == ST_STORE);
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ld_m[i] = w_src_y ? i_item.ymag[i] : 64'(i_item.xmag[i]);
        end
    end
    assign w_zero     = (w_ld_m[0] == 0) && (w_ld_m[1] == 0) && (w_ld_m[2] == 0);
    assign w_hi       = (|r_m[0][63:31]) || (|r_m[1][63:31]) || (|r_m[2][63:31]);
    assign w_lo       = !(|r_m[0][63:30]) && !(|r_m[1][63:30]) && !(|r_m[2][63:30]);
    assign w_out_free = !r_ov || i_pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = w_zero ? ST_DONE : ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (!w_hi && !w_lo) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (r_cnt == CW'(2)) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (r_cnt == CW'(31)) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (r_cnt == CW'(FRAC_BITS)) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                n_state = (r_vsel || w_zero) ? ST_DONE : ST_SHIFT;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    logic w_load, w_fin, w_sq_end;

    always_comb begin
        w_load   = 1'b0;
        w_fin    = 1'b0;
        w_sq_end = 1'b0;
        case (r_state)
            ST_IDLE:   w_load   = !i_q_empty;
            ST_SQUARE: w_sq_end = (r_cnt == CW'(2));
            ST_STORE:  w_load   = !r_vsel;
            ST_DONE:   w_fin    = w_out_free;
            default:   w_load   = 1'b0;
        endcase
    end

    assign o_q_pop = w_fin;

    logic [63:0] w_sq_op, w_sq, w_try;
    logic [2:0]  w_neg;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_sq_op = r_m[0];
            2'd1:    w_sq_op = r_m[1];
            default: w_sq_op = r_m[2];
        endcase
    end
    assign w_sq    = w_sq_op[30:0] * w_sq_op[30:0];
    assign w_try   = r_res + r_bit;
    assign w_neg   = r_vsel ? i_item.yneg : i_item.xneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : r_cnt + 1'b1;
            if (w_fin) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i] <= w_ld_m[i];
            end
            r_vsel  <= w_src_y;
            r_degen <= w_zero;
        end
        case (r_state)
            ST_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    if (w_hi) begin
                        r_m[i] <= r_m[i] >> 1;
                    end else if (w_lo) begin
                        r_m[i] <= r_m[i] << 1;
                    end
                end
            end
            ST_SQUARE: begin
                r_len2 <= ((r_cnt == '0) ? 64'd0 : r_len2) + w_sq;
                if (w_sq_end) begin
                    r_res <= '0;
                    r_bit <= 64'd1 << 62;
                end
            end
            ST_ROOT: begin
                if (r_len2 >= w_try) begin
                    r_len2 <= r_len2 - w_try;
                    r_res  <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_DIVIDE: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_cnt == '0) begin
                        if ({1'b0, r_m[i][30:0]} >= r_res[31:0]) begin
                            r_rem[i] <= {1'b0, r_m[i][30:0]} - r_res[31:0];
                            r_q[i]   <= 64'd1;
                        end else begin
                            r_rem[i] <= {1'b0, r_m[i][30:0]};
                            r_q[i]   <= 64'd0;
                        end
                    end else if ({r_rem[i], 1'b0} >= {1'b0, r_res[31:0]}) begin
                        r_rem[i] <= 32'({r_rem[i], 1'b0} - {1'b0, r_res[31:0]});
                        r_q[i]   <= {r_q[i][62:0], 1'b1};
                    end else begin
                        r_rem[i] <= {r_rem[i][30:0], 1'b0};
                        r_q[i]   <= {r_q[i][62:0], 1'b0};
                    end
                end
            end
            ST_STORE: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_vsel) begin
                        r_y[i] <= enc(w_neg[i], r_q[i]);
                    end else begin
                        r_x[i] <= enc(w_neg[i], r_q[i]);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            o_xaxis <= r_degen ? '0 : r_x;
            o_yaxis <= r_degen ? '0 : r_y;
            o_zrow  <= r_degen ? '0 : i_zrow;
            o_cap   <= i_item.cap;
            o_degen <= r_degen;
        end
    end

    assign o_empty = !r_ov;

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> !o_empty)
        else $error("result word lost on queue pop");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_degen) |-> (o_xaxis == '0 && o_yaxis == '0 && o_zrow == '0))
        else $error("degenerate word carries nonzero rows");

    a_root_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT) |-> $onehot(r_bit))
        else $error("root trial bit not one-hot");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQUARE) |-> (!w_hi && !w_lo))
        else $error("magnitudes not normalized before squaring");

endmodule

// ===== hw/rtl/arbitrary_axis_frame.sv =====
// The front registers a word in stages A and B before the internal queue; the normalizer
// then works per axis (one-bit shift search, 3 squares, 32 root steps, FRAC_BITS+1
// divide steps); a degenerate normal skips these steps and goes straight to the result.
// Throughput: one word per normalizer pass; the front takes a word every cycle until
// its 4-entry queue and 2 stages fill.
// Reset: synchronous active-low i_rst_n empties the pipeline, queue and result register.
module arbitrary_axis_frame #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [DATA_WIDTH-1:0] i_normal_x,
    input  logic signed [DATA_WIDTH-1:0] i_normal_y,
    input  logic signed [DATA_WIDTH-1:0] i_normal_z,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [DATA_WIDTH-1:0] o_xaxis_x,
    output logic signed [DATA_WIDTH-1:0] o_xaxis_y,
    output logic signed [DATA_WIDTH-1:0] o_xaxis_z,
    output logic signed [DATA_WIDTH-1:0] o_yaxis_x,
    output logic signed [DATA_WIDTH-1:0] o_yaxis_y,
    output logic signed [DATA_WIDTH-1:0] o_yaxis_z,
    output logic signed [DATA_WIDTH-1:0] o_zrow_x,
    output logic signed [DATA_WIDTH-1:0] o_zrow_y,
    output logic signed [DATA_WIDTH-1:0] o_zrow_z,
    output logic                         o_in_polar_cap,
    output logic                         o_degenerate
);
    import afr_pkg::*;

    localparam int QW = $bits(t_item) + 3 * DATA_WIDTH;

    t_item                    w_f_item, w_q_item;
    logic [3*DATA_WIDTH-1:0]  w_f_z, w_q_z, w_o_z;
    logic                     w_q_push, w_q_full, w_q_pop, w_q_empty;
    logic [2:0][DATA_WIDTH-1:0] w_xo, w_yo;

    afr_front #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_nx    (i_normal_x),
        .i_ny    (i_normal_y),
        .i_nz    (i_normal_z),
        .i_q_full(w_q_full),
        .o_q_push(w_q_push),
        .o_item  (w_f_item),
        .o_zrow  (w_f_z)
    );

    afr_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_data ({w_f_item, w_f_z}),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_empty(w_q_empty),
        .o_data ({w_q_item, w_q_z})
    );

    afr_back #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(w_q_empty),
        .i_item   (w_q_item),
        .i_zrow   (w_q_z),
        .o_q_pop  (w_q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_xaxis  (w_xo),
        .o_yaxis  (w_yo),
        .o_zrow   (w_o_z),
        .o_cap    (o_in_polar_cap),
        .o_degen  (o_degenerate)
    );

    assign o_xaxis_x = w_xo[0];
    assign o_xaxis_y = w_xo[1];
    assign o_xaxis_z = w_xo[2];
    assign o_yaxis_x = w_yo[0];
    assign o_yaxis_y = w_yo[1];
    assign o_yaxis_z = w_yo[2];
    assign o_zrow_x  = w_o_z[DATA_WIDTH-1:0];
    assign o_zrow_y  = w_o_z[2*DATA_WIDTH-1:DATA_WIDTH];
    assign o_zrow_z  = w_o_z[3*DATA_WIDTH-1:2*DATA_WIDTH];

endmodule
